@@ hdl/lbd_pkg.sv @@
// Package for the ladder button debouncer: widths, register indexes,
// ladder voltage windows, event codes and the ladder-to-button mapping.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbd_pkg;

    localparam int TIME_BITS = 32;
    localparam int ADC_BITS  = 10;
    localparam int CFG_BITS  = 16;
    localparam int BTN_BITS  = 3;
    localparam int IDX_BITS  = 2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ADC_BITS-1:0]  adc_t;
    typedef logic [CFG_BITS-1:0]  cfg_t;
    typedef logic [BTN_BITS-1:0]  btn_t;
    typedef logic [IDX_BITS-1:0]  cfg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    localparam cfg_idx_t REG_SAMPLE_INTERVAL = 2'd0;
    localparam cfg_idx_t REG_DEBOUNCE        = 2'd1;
    localparam cfg_idx_t REG_TIMEOUT         = 2'd2;
    localparam cfg_idx_t REG_HINT_THRESHOLD  = 2'd3;

    localparam cfg_t RST_SAMPLE_INTERVAL = 16'd5;
    localparam cfg_t RST_DEBOUNCE        = 16'd30;
    localparam cfg_t RST_TIMEOUT         = 16'd300;
    localparam adc_t RST_HINT_THRESHOLD  = 10'd512;

    localparam adc_t LAD_NONE_MAX = 10'd50;
    localparam adc_t LAD_B3_LO    = 10'd200;
    localparam adc_t LAD_B3_HI    = 10'd300;
    localparam adc_t LAD_B2_LO    = 10'd450;
    localparam adc_t LAD_B2_HI    = 10'd550;
    localparam adc_t LAD_B1_LO    = 10'd700;
    localparam adc_t LAD_B1_HI    = 10'd800;
    localparam adc_t LAD_B4_LO    = 10'd950;

    localparam btn_t BTN_NONE = 3'd0;
    localparam btn_t BTN_1    = 3'd1;
    localparam btn_t BTN_2    = 3'd2;
    localparam btn_t BTN_3    = 3'd3;
    localparam btn_t BTN_4    = 3'd4;
    localparam btn_t BTN_HINT = 3'd5;

    function automatic btn_t map_buttons(input adc_t v, input adc_t hint, input adc_t thresh);
        btn_t b;
        if (v < LAD_NONE_MAX)
            b = BTN_NONE;
        else if (v > LAD_B3_LO && v < LAD_B3_HI)
            b = BTN_3;
        else if (v > LAD_B2_LO && v < LAD_B2_HI)
            b = BTN_2;
        else if (v > LAD_B1_LO && v < LAD_B1_HI)
            b = BTN_1;
        else if (v > LAD_B4_LO)
            b = BTN_4;
        else if (hint > thresh)
            b = BTN_HINT;
        else
            b = BTN_NONE;
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ladder_button_debouncer_core.sv @@
// Top level of the ladder button debouncer: poll register, decision logic,
// debounce/window state and result register.
// Depends on lbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one poll transaction (timestamp plus ladder and hint ADC samples) per
// clock unless stalled and returns exactly one result per poll, in order. The
// poll is held in an input register; the window, throttle, mapping and debounce
// decision is one pass of compares and 32-bit subtractions into the result
// register, so the sustained rate is one poll per cycle when the output is not
// stalled. A stalled result register holds its transaction while the next poll
// still waits in the input register. Configuration writes are taken at any cycle
// and must only be issued while no poll is in flight.
module ladder_button_debouncer_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire lbd_pkg::cfg_idx_t  cfg_index,
    input  wire lbd_pkg::cfg_t      cfg_data,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire lbd_pkg::time_t     now_ms,
    input  wire lbd_pkg::adc_t      ladder_sample,
    input  wire lbd_pkg::adc_t      hint_sample,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [1:0]              event_res,
    output lbd_pkg::btn_t           button
);

    localparam int PAD = lbd_pkg::TIME_BITS - lbd_pkg::CFG_BITS;

    lbd_pkg::cfg_t  sample_interval_reg;
    lbd_pkg::cfg_t  debounce_reg;
    lbd_pkg::cfg_t  timeout_reg;
    lbd_pkg::adc_t  hint_threshold_reg;

    logic           poll_valid_reg;
    lbd_pkg::time_t poll_now_reg;
    lbd_pkg::adc_t  poll_ladder_reg;
    lbd_pkg::adc_t  poll_hint_reg;

    lbd_pkg::time_t last_sample_reg, last_sample_next;
    lbd_pkg::btn_t  stable_reg, stable_next;
    lbd_pkg::btn_t  cand_reg, cand_next;
    lbd_pkg::time_t cand_start_reg, cand_start_next;
    lbd_pkg::time_t win_start_reg, win_start_next;
    logic           win_open_reg, win_open_next;

    logic            out_valid_reg;
    lbd_pkg::event_t out_event_reg, out_event_next;
    lbd_pkg::btn_t   out_button_reg, out_button_next;

    logic           advance;
    logic           in_take;
    lbd_pkg::time_t win_age;
    lbd_pkg::time_t since_sample;
    lbd_pkg::time_t cand_age;
    lbd_pkg::btn_t  reading;
    logic           timed_out;
    logic           throttled;
    logic           settled;

    assign advance  = poll_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !poll_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign button    = out_button_reg;

    always_comb
    begin
        win_start_next   = win_open_reg ? win_start_reg : poll_now_reg;
        win_age          = poll_now_reg - win_start_next;
        since_sample     = poll_now_reg - last_sample_reg;
        cand_age         = poll_now_reg - cand_start_reg;
        reading          = lbd_pkg::map_buttons(poll_ladder_reg, poll_hint_reg,
                                                hint_threshold_reg);
        timed_out        = (timeout_reg != '0) && (win_age >= {{PAD{1'b0}}, timeout_reg});
        throttled        = since_sample < {{PAD{1'b0}}, sample_interval_reg};
        settled          = cand_age >= {{PAD{1'b0}}, debounce_reg};

        win_open_next    = 1'b1;
        last_sample_next = last_sample_reg;
        stable_next      = stable_reg;
        cand_next        = cand_reg;
        cand_start_next  = cand_start_reg;
        out_event_next   = lbd_pkg::EV_NONE;
        out_button_next  = lbd_pkg::BTN_NONE;

        if (timed_out)
        begin
            win_open_next   = 1'b0;
            cand_next       = stable_reg;
            cand_start_next = poll_now_reg;
            out_event_next  = lbd_pkg::EV_TIMEOUT;
        end
        else if (!throttled)
        begin
            last_sample_next = poll_now_reg;
            if (reading != cand_reg)
            begin
                cand_next       = reading;
                cand_start_next = poll_now_reg;
            end
            else if (cand_reg != stable_reg && settled)
            begin
                stable_next = cand_reg;
                // press edge: idle to a button
                if (stable_reg == lbd_pkg::BTN_NONE && cand_reg != lbd_pkg::BTN_NONE)
                begin
                    win_open_next   = 1'b0;
                    out_event_next  = lbd_pkg::EV_PRESS;
                    out_button_next = cand_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= lbd_pkg::RST_SAMPLE_INTERVAL;
            debounce_reg        <= lbd_pkg::RST_DEBOUNCE;
            timeout_reg         <= lbd_pkg::RST_TIMEOUT;
            hint_threshold_reg  <= lbd_pkg::RST_HINT_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbd_pkg::REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                lbd_pkg::REG_DEBOUNCE:        debounce_reg        <= cfg_data;
                lbd_pkg::REG_TIMEOUT:         timeout_reg         <= cfg_data;
                lbd_pkg::REG_HINT_THRESHOLD:
                    hint_threshold_reg <= cfg_data[lbd_pkg::ADC_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_sample_reg <= '0;
            stable_reg      <= lbd_pkg::BTN_NONE;
            cand_reg        <= lbd_pkg::BTN_NONE;
            cand_start_reg  <= '0;
            win_start_reg   <= '0;
            win_open_reg    <= 1'b0;
        end
        else
        begin
            if (in_take)
                poll_valid_reg <= 1'b1;
            else if (advance)
                poll_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                last_sample_reg <= last_sample_next;
                stable_reg      <= stable_next;
                cand_reg        <= cand_next;
                cand_start_reg  <= cand_start_next;
                win_start_reg   <= win_start_next;
                win_open_reg    <= win_open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_now_reg    <= now_ms;
            poll_ladder_reg <= ladder_sample;
            poll_hint_reg   <= hint_sample;
        end
        if (advance)
        begin
            out_event_reg  <= out_event_next;
            out_button_reg <= out_button_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lbd_checker.sv @@
// Port-level checker for the ladder button debouncer and its bind.
// Depends on lbd_pkg and ladder_button_debouncer_core.
`timescale 1ns / 1ps
`default_nettype none

module lbd_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_ready,
    input wire [1:0]          event_res,
    input wire lbd_pkg::btn_t button
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(button))
        else $error("result changed while stalled");

    a_press_button: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == lbd_pkg::EV_PRESS |->
            button != lbd_pkg::BTN_NONE && button <= lbd_pkg::BTN_HINT)
        else $error("press without valid button");

    a_other_button: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != lbd_pkg::EV_PRESS |-> button == lbd_pkg::BTN_NONE)
        else $error("button reported outside a press");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res == lbd_pkg::EV_NONE || event_res == lbd_pkg::EV_PRESS ||
            event_res == lbd_pkg::EV_TIMEOUT)
        else $error("unknown event code");

endmodule

bind ladder_button_debouncer_core lbd_checker u_lbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .button    (button)
);

`default_nettype wire
